// ===== design/lrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and codes of the LRU recency stack
// Command and status codes and the packed request and response items.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam int REQ_TAG_BITS = 22;
   localparam int SLOT_BITS    = 3;
   localparam int OCC_BITS     = 4;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_MOVE   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_STATUS = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [REQ_TAG_BITS-1:0] new_tag;
      logic                    new_dirty;
      logic [SLOT_BITS-1:0]    slot;
   } req_type;

   typedef struct packed {
      logic [OCC_BITS-1:0]     occupancy;
      logic                    lru_valid;
      logic [REQ_TAG_BITS-1:0] lru_tag;
      logic                    lru_dirty;
      logic [1:0]              status;
   } rsp_type;

endpackage

// ===== design/lru_recency_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_stack: LRU replacement stack of one cache set
// Takes one command a cycle and reports occupancy and the LRU entry.
// ----------------------------------------------------------------------------
// One command can be started in every clock cycle: busy stays low, so a
// command is taken at any edge where start is high. Each command produces
// exactly one response, strobed by rsp_valid for a single cycle. The command
// first sits in the command register while the stack update is worked out,
// and the edge that ends its stay there writes both the stack and the
// response register, which drives rsp_valid. The response reflects the stack
// after that command, and commands act in the order they were taken, so a
// command sees everything the previous one did. There is no way to hold
// a response off: capture it in the cycle rsp_valid is high or lose it.
// An insert into a full stack returns STATUS_FULL and changes nothing; a move
// from a position at or beyond the occupancy returns STATUS_BAD_SLOT. When
// the stack is empty lru_valid is low and lru_tag and lru_dirty read zero.
// ----------------------------------------------------------------------------
module lru_recency_stack
   import lrs_pkg::*;
#(
   parameter int WAYS     = 8,
   parameter int TAG_BITS = 22
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    req_xfer;

   // never stall the request side
   assign busy     = 1'b0;
   assign req_xfer = start && !busy;

   // hold the command for its update cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
   end

   lrs_core #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cmd_en  (req_valid_ff),
      .cmd_req (req_ff),
      .cmd_rsp (core_rsp)
   );

   // register the response; strobe it for one cycle per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/lrs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_core: recency stack storage and single-pass update
// Holds the entries and the count, applies one command per enabled cycle and
// presents the post-command view of the stack.
// ----------------------------------------------------------------------------
module lrs_core
   import lrs_pkg::*;
#(
   parameter int WAYS     = 8,
   parameter int TAG_BITS = 22
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_en,
   input  req_type cmd_req,
   output rsp_type cmd_rsp
);

   localparam int CW  = $clog2(WAYS + 1);
   localparam int IW  = $clog2(WAYS);
   localparam int SB  = (TAG_BITS < REQ_TAG_BITS) ? TAG_BITS : REQ_TAG_BITS;
   localparam int CMW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

   logic [SB-1:0] tags_ff  [WAYS];
   logic [SB-1:0] tags_in  [WAYS];
   logic          dirty_ff [WAYS];
   logic          dirty_in [WAYS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic [CMW-1:0] slot_ext;
   logic [CMW-1:0] count_ext;
   logic [IW-1:0]  slot_idx;
   logic [IW-1:0]  tail_idx;
   logic           do_insert;
   logic           do_move;
   logic [1:0]     status;
   logic [SB-1:0]  move_tag;
   logic           move_dirty;

   assign slot_ext   = CMW'(cmd_req.slot);
   assign count_ext  = CMW'(count_ff);
   assign slot_idx   = IW'(slot_ext);
   assign move_tag   = tags_ff[slot_idx];
   assign move_dirty = dirty_ff[slot_idx];

   // decode the command against the current fill
   always_comb begin
      do_insert = 1'b0;
      do_move   = 1'b0;
      status    = STATUS_OK;
      count_in  = count_ff;
      unique case (cmd_req.cmd)
         CMD_INSERT: begin
            if (count_ff >= CW'(WAYS)) begin
               status = STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_MOVE: begin
            if (slot_ext >= count_ext) begin
               status = STATUS_BAD_SLOT;
            end else begin
               do_move = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
         end
         CMD_STATUS: begin
            status = STATUS_OK;
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   // shift entries down one position toward the tail where needed
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         tags_in[i]  = tags_ff[i];
         dirty_in[i] = dirty_ff[i];
         if (i == 0) begin
            if (do_insert) begin
               tags_in[i]  = SB'(cmd_req.new_tag);
               dirty_in[i] = cmd_req.new_dirty;
            end else if (do_move) begin
               tags_in[i]  = move_tag;
               dirty_in[i] = move_dirty;
            end
         end else if (do_insert || (do_move && (CMW'(i) <= slot_ext))) begin
            tags_in[i]  = tags_ff[i-1];
            dirty_in[i] = dirty_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd_en) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_en) begin
         for (int i = 0; i < WAYS; i++) begin
            tags_ff[i]  <= tags_in[i];
            dirty_ff[i] <= dirty_in[i];
         end
      end
   end

   // report the tail as it stands after the command
   assign tail_idx = IW'(count_in - CW'(1));

   always_comb begin
      cmd_rsp.occupancy = OCC_BITS'(count_in);
      cmd_rsp.status    = status;
      if (count_in != '0) begin
         cmd_rsp.lru_valid = 1'b1;
         cmd_rsp.lru_tag   = REQ_TAG_BITS'(tags_in[tail_idx]);
         cmd_rsp.lru_dirty = dirty_in[tail_idx];
      end else begin
         cmd_rsp.lru_valid = 1'b0;
         cmd_rsp.lru_tag   = '0;
         cmd_rsp.lru_dirty = 1'b0;
      end
   end

endmodule

// ===== design/lrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker: port-level checks of the LRU recency stack
// Watches command and response transfers and the response contents.
// ----------------------------------------------------------------------------
module lrs_checker
   import lrs_pkg::*;
#(
   parameter int WAYS = 8
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every taken command gets its response through the command and response registers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response missing after command transfer");

   // no response without a command
   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##2 !rsp_valid)
      else $error("response without command transfer");

   // occupancy and the valid flag agree, and an empty stack reports zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.lru_valid == (rsp_data.occupancy != '0))
                    && (rsp_data.lru_valid
                        || (rsp_data.lru_tag == '0 && !rsp_data.lru_dirty)))
      else $error("LRU view inconsistent with occupancy");

   // a refused insert only happens on a full stack
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL)
         |-> (rsp_data.occupancy == OCC_BITS'(WAYS)))
      else $error("insert refused on a stack that is not full");

endmodule

bind lru_recency_stack lrs_checker #(.WAYS(WAYS)) u_lrs_checker (.*);
